[rtl/swct_pkg.sv]
// ----------------------------------------------------------------------------
// swct_pkg
// types and constants shared by the sliding-window credit tracker
// ----------------------------------------------------------------------------
package swct_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_MUT   = 2'd1,
        CMD_CROSS = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CT_EXTREME = 2'd0,
        CT_AVERAGE = 2'd1,
        CT_RECENT  = 2'd2,
        CT_ZERO    = 2'd3
    } ctype_t;

    localparam logic [2:0] REG_WINDOW_SIZE = 3'd0;
    localparam logic [2:0] REG_CREDIT_TYPE = 3'd1;
    localparam logic [2:0] REG_NORMALIZE   = 3'd2;
    localparam logic [2:0] REG_DELTA       = 3'd3;
    localparam logic [2:0] REG_MAX_REWARD  = 3'd4;

    localparam int          CFG_IDX_W      = 3;
    localparam logic [30:0] CREDIT_MAX     = 31'h7fff_ffff;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_WAIT,
        ST_WRITE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_RECENT_RD,
        ST_RECENT_WAIT,
        ST_CREDIT,
        ST_AVG_DIV,
        ST_NORM_DIV,
        ST_OUT
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

[rtl/sliding_window_credit_tracker_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_credit_tracker_core
// ring of recent rewards with running sum and best, credit selection and
// normalization through one shared serial divider
// ----------------------------------------------------------------------------
// One beat in, one beat out. When the evicted reward was the best, the
// ring is rescanned for a new best through the ring memory read port, one
// entry a cycle, and the average credit and normalization each divide
// through the shared 64-step divider. The block is not ready while an item
// runs.
module sliding_window_credit_tracker_core #(
    parameter int WINDOW_MAX = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [swct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic signed [31:0]           s_old_a,
    input  logic signed [31:0]           s_old_b,
    input  logic signed [31:0]           s_new_a,
    input  logic signed [31:0]           s_new_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [30:0]                  m_credit,
    output logic [30:0]                  m_credit_raw,
    output logic [6:0]                   m_window_count,
    output logic                         m_window_full
);
    import swct_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = 32 + CW;
    localparam logic [CW-1:0] WMAX = CW'(WINDOW_MAX);

    // config
    logic [6:0]  wsize_reg;
    ctype_t      ctype_reg;
    logic        norm_reg, delta_reg;
    logic [30:0] maxr_reg;

    // state
    state_t         st_reg, st_next;
    logic [AW-1:0]  newest_reg, newest_next;
    logic [CW-1:0]  held_reg, held_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [31:0] best_reg, best_next;
    logic signed [31:0] rew_reg, rew_next;
    logic           evict_reg, evict_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [30:0]    raw_reg, raw_next;
    logic [30:0]    cred_reg, cred_next;
    logic           mval_reg, mval_next;

    // ring memory
    logic signed [31:0] ring [WINDOW_MAX];
    logic signed [31:0] rd_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    div_req_t dreq;
    div_rsp_t drsp;

    swct_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_ff @(posedge aclk) begin
        if (wr_en) ring[wr_addr] <= rew_reg;
        rd_reg <= ring[rd_addr];
    end

    // effective window
    logic [CW-1:0] weff;
    always_comb begin
        if (wsize_reg == 7'd0) weff = CW'(1);
        else if ({25'd0, wsize_reg} > 32'(WINDOW_MAX)) weff = WMAX;
        else weff = CW'(wsize_reg);
    end

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW+AW:0] s;
        s = {{(CW+1){1'b0}}, a} + {{(AW+1){1'b0}}, b};
        if (s >= (CW+AW+1)'(WINDOW_MAX)) s = s - (CW+AW+1)'(WINDOW_MAX);
        return s[AW-1:0];
    endfunction

    // reward derivation
    logic signed [31:0] bo, bn, derived;
    logic signed [32:0] diff;
    always_comb begin
        bo = s_old_a;
        bn = s_new_a;
        if (cmd_t'(s_cmd) == CMD_CROSS) begin
            if (s_old_b > s_old_a) bo = s_old_b;
            if (s_new_b > s_new_a) bn = s_new_b;
        end
        diff = 33'(bn) - 33'(bo);
        if (delta_reg) begin
            if (diff > 33'sd2147483647) derived = 32'sh7fffffff;
            else if (diff < -33'sd2147483648) derived = 32'sh80000000;
            else derived = diff[31:0];
        end else begin
            derived = (diff <= 0) ? 32'sd0 : bn;
        end
        if (cmd_t'(s_cmd) == CMD_ADD) derived = s_new_a;
    end

    // oldest slot with current held count
    logic [AW-1:0] oldest;
    assign oldest = wrap_add(newest_reg, WMAX - held_reg + CW'(1));

    logic [30:0] clamp;
    logic signed [SW-1:0] sum_abs;
    logic [63:0] avg_q;
    logic signed [SW-1:0] avg_s;

    assign sum_abs = sum_reg[SW-1] ? -sum_reg : sum_reg;
    assign avg_q = drsp.quotient;
    assign avg_s = sum_reg[SW-1] ? -SW'(avg_q) : SW'(avg_q);

    always_comb begin
        st_next     = st_reg;
        newest_next = newest_reg;
        held_next   = held_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        rew_next    = rew_reg;
        evict_next  = evict_reg;
        scan_next   = scan_reg;
        ptr_next    = ptr_reg;
        raw_next    = raw_reg;
        cred_next   = cred_reg;
        mval_next   = mval_reg;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = newest_reg;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;
        clamp       = '0;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (cmd_t'(s_cmd) == CMD_CLEAR) begin
                        newest_next = '0;
                        held_next   = '0;
                        sum_next    = '0;
                        best_next   = '0;
                        st_next     = ST_CREDIT;
                    end else begin
                        rew_next   = derived;
                        evict_next = (held_reg + CW'(1)) > weff;
                        ptr_next   = oldest;
                        st_next    = ST_EVICT_RD;
                    end
                end
            end
            ST_EVICT_RD: begin
                rd_addr = ptr_reg;
                st_next = ST_EVICT_WAIT;
            end
            ST_EVICT_WAIT: begin
                // rd_reg holds evicted entry when evicting
                wr_en       = 1'b1;
                wr_addr     = wrap_add(newest_reg, CW'(1));
                newest_next = wr_addr;
                sum_next    = sum_reg + SW'(rew_reg) - (evict_reg ? SW'(rd_reg) : SW'(0));
                if (rew_reg > best_reg) best_next = rew_reg;
                st_next     = ST_CREDIT;
                if (!evict_reg) begin
                    held_next = held_reg + CW'(1);
                end else if (rd_reg == ((rew_reg > best_reg) ? rew_reg : best_reg)) begin
                    best_next = '0;
                    ptr_next  = wrap_add(ptr_reg, CW'(1));
                    scan_next = held_reg;
                    st_next   = ST_WRITE;
                end
            end
            ST_WRITE: begin
                rd_addr   = ptr_reg;
                ptr_next  = wrap_add(ptr_reg, CW'(1));
                scan_next = scan_reg - CW'(1);
                st_next   = ST_SCAN;
            end
            ST_SCAN: begin
                rd_addr = ptr_reg;
                if (rd_reg > best_reg) best_next = rd_reg;
                if (scan_reg == '0) begin
                    st_next = ST_CREDIT;
                end else begin
                    ptr_next  = wrap_add(ptr_reg, CW'(1));
                    scan_next = scan_reg - CW'(1);
                end
            end
            ST_SCAN_LAST: st_next = ST_CREDIT;
            ST_CREDIT: begin
                unique case (ctype_reg)
                    CT_EXTREME: begin
                        raw_next = best_reg[31] ? 31'd0 : best_reg[30:0];
                        st_next  = ST_NORM_DIV;
                    end
                    CT_AVERAGE: begin
                        if (held_reg == '0) begin
                            raw_next = '0;
                            st_next  = ST_NORM_DIV;
                        end else begin
                            dreq.start    = 1'b1;
                            dreq.dividend = 64'(sum_abs);
                            dreq.divisor  = 64'(held_reg);
                            st_next       = ST_AVG_DIV;
                        end
                    end
                    CT_RECENT: begin
                        if (held_reg == '0) begin
                            raw_next = '0;
                            st_next  = ST_NORM_DIV;
                        end else begin
                            rd_addr = newest_reg;
                            st_next = ST_RECENT_RD;
                        end
                    end
                    CT_ZERO: begin
                        raw_next = '0;
                        st_next  = ST_NORM_DIV;
                    end
                    default: st_next = ST_NORM_DIV;
                endcase
                if (st_next == ST_NORM_DIV) begin
                    cred_next = (ctype_reg == CT_EXTREME && !best_reg[31]) ?
                                best_reg[30:0] : 31'd0;
                end
            end
            ST_RECENT_RD: begin
                rd_addr = newest_reg;
                st_next = ST_RECENT_WAIT;
            end
            ST_RECENT_WAIT: begin
                raw_next = rd_reg[31] ? 31'd0 : rd_reg[30:0];
                st_next  = ST_NORM_DIV;
            end
            ST_AVG_DIV: begin
                if (drsp.done) begin
                    if (avg_s < 0) raw_next = '0;
                    else if (avg_s > SW'(CREDIT_MAX)) raw_next = CREDIT_MAX;
                    else raw_next = avg_s[30:0];
                    st_next = ST_NORM_DIV;
                    evict_next = 1'b0;
                end
            end
            ST_NORM_DIV: begin
                // evict_reg marks divide in flight here
                if (!(norm_reg && maxr_reg != '0)) begin
                    cred_next = raw_reg;
                    mval_next = 1'b1;
                    st_next   = ST_OUT;
                end else if (!evict_reg) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'(raw_reg) << FRAC_BITS;
                    dreq.divisor  = 64'(maxr_reg);
                    evict_next    = 1'b1;
                end else if (drsp.done) begin
                    clamp     = (drsp.quotient > 64'(CREDIT_MAX)) ? CREDIT_MAX
                                                                 : drsp.quotient[30:0];
                    cred_next = clamp;
                    mval_next = 1'b1;
                    st_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    mval_next = 1'b0;
                    st_next   = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
        // make sure norm stage starts with no divide pending
        if (st_reg != ST_NORM_DIV && st_next == ST_NORM_DIV) evict_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            newest_reg <= '0;
            held_reg   <= '0;
            sum_reg    <= '0;
            best_reg   <= '0;
            evict_reg  <= 1'b0;
            mval_reg   <= 1'b0;
            wsize_reg  <= 7'd64;
            ctype_reg  <= CT_EXTREME;
            norm_reg   <= 1'b0;
            delta_reg  <= 1'b0;
            maxr_reg   <= '0;
        end else begin
            st_reg     <= st_next;
            newest_reg <= newest_next;
            held_reg   <= held_next;
            sum_reg    <= sum_next;
            best_reg   <= best_next;
            evict_reg  <= evict_next;
            mval_reg   <= mval_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_WINDOW_SIZE: wsize_reg <= cfg_data[6:0];
                    REG_CREDIT_TYPE: ctype_reg <= ctype_t'(cfg_data[1:0]);
                    REG_NORMALIZE:   norm_reg  <= cfg_data[0];
                    REG_DELTA:       delta_reg <= cfg_data[0];
                    REG_MAX_REWARD:  maxr_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
        rew_reg  <= rew_next;
        scan_reg <= scan_next;
        ptr_reg  <= ptr_next;
        raw_reg  <= raw_next;
        cred_reg <= cred_next;
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = (st_reg == ST_IDLE);
    assign m_valid        = mval_reg;
    assign m_credit       = cred_reg;
    assign m_credit_raw   = raw_reg;
    assign m_window_count = 7'(held_reg);
    assign m_window_full  = (held_reg >= weff);
endmodule

[rtl/swct_divider.sv]
// ----------------------------------------------------------------------------
// swct_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module swct_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  swct_pkg::div_req_t req,
    output swct_pkg::div_rsp_t rsp
);
    import swct_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[62:0], quo_reg[63]};
        trial     = {1'b0, shifted} - {1'b0, dsr_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg[63] || !trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

[rtl/swct_checker.sv]
// ----------------------------------------------------------------------------
// swct_checker
// port-level checks on the credit tracker
// ----------------------------------------------------------------------------
module swct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_credit,
    input logic [6:0]  m_window_count
);
    // no new beat while a result is pending
    a_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");

    // result holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_credit))
        else $error("result changed while stalled");

    // ready drops in the next cycle once an input is accepted
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");

    // count never beyond 64
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_window_count <= 7'd64) else $error("count out of range");
endmodule

bind sliding_window_credit_tracker_core swct_checker u_swct_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_credit(m_credit),
    .m_window_count(m_window_count)
);

[tb/tb_sliding_window_credit_tracker_core.sv]
// ----------------------------------------------------------------------------
// tb_sliding_window_credit_tracker_core
// self-checking bench: random and directed reward beats against a built-in
// predictor of the reward window, credit selection and normalization
// ----------------------------------------------------------------------------
module tb_sliding_window_credit_tracker_core;
    import swct_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] old_a;
        logic [31:0] old_b;
        logic [31:0] new_a;
        logic [31:0] new_b;
    } beat_t;

    typedef struct packed {
        logic [30:0] credit;
        logic [30:0] credit_raw;
        logic [6:0]  count;
        logic        full;
    } credit_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic signed [31:0] s_old_a = '0, s_old_b = '0, s_new_a = '0, s_new_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [30:0] m_credit, m_credit_raw;
    logic [6:0]  m_window_count;
    logic        m_window_full;

    sliding_window_credit_tracker_core u_top (.*);

    // predictor state
    logic signed [31:0] ring [64];
    int unsigned        newest, held;
    longint             wsum;
    logic signed [31:0] best;
    int unsigned        win_size, ctype, norm_en, delta_en;
    longint unsigned    max_rew;

    beat_t   pending_beats[$];
    credit_t expected_credits[$];
    int      mismatches = 0;
    int      results_seen = 0;
    longint  cycles = 0;
    int      send_gap = 0, recv_gap = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int unsigned eff_win();
        if (win_size < 1) return 1;
        if (win_size > 64) return 64;
        return win_size;
    endfunction

    function automatic int unsigned oldest_slot();
        return (newest + 64 - (held - 1)) % 64;
    endfunction

    function automatic void push_reward(logic signed [31:0] r);
        bit evict;
        logic signed [31:0] gone;
        int unsigned start;
        evict = (held + 1) > eff_win();
        gone = 0;
        if (evict) gone = ring[oldest_slot()];
        newest = (newest + 1) % 64;
        ring[newest] = r;
        held++;
        wsum += r;
        if (r > best) best = r;
        if (evict) begin
            wsum -= gone;
            held--;
            if (gone == best) begin
                start = oldest_slot();
                best = 0;
                for (int i = 0; i < held; i++)
                    if (ring[(start + i) % 64] > best) best = ring[(start + i) % 64];
            end
        end
    endfunction

    function automatic logic signed [31:0] fitness_reward(longint ov, longint nv);
        longint d;
        d = nv - ov;
        if (delta_en != 0) return sat32(d);
        if (d <= 0) return 0;
        return nv[31:0];
    endfunction

    function automatic credit_t predict_credit(beat_t b);
        credit_t r;
        longint oa, ob, na, nb, c;
        longint unsigned q;
        oa = $signed(b.old_a);
        ob = $signed(b.old_b);
        na = $signed(b.new_a);
        nb = $signed(b.new_b);
        case (b.cmd)
            CMD_ADD:   push_reward(b.new_a);
            CMD_MUT:   push_reward(fitness_reward(oa, na));
            CMD_CROSS: push_reward(fitness_reward(oa > ob ? oa : ob, na > nb ? na : nb));
            default: begin
                newest = 0; held = 0; wsum = 0; best = 0;
            end
        endcase
        c = 0;
        case (ctype)
            CT_EXTREME: c = best;
            CT_AVERAGE: if (held > 0) c = wsum / longint'(held);
            CT_RECENT:  if (held > 0) c = ring[newest];
            default:    c = 0;
        endcase
        if (c < 0) c = 0;
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        q = c;
        if (norm_en != 0 && max_rew != 0) begin
            q = (longint'(c) << 16) / max_rew;
            if (q > 64'd2147483647) q = 64'd2147483647;
        end
        r.credit = q[30:0];
        r.credit_raw = c[30:0];
        r.count = held[6:0];
        r.full = held >= eff_win();
        return r;
    endfunction

    // input driver, gap drawn per beat and applied after its accept
    always @(posedge aclk) begin
        beat_t nxt;
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                // hold the beat until accepted
            end else if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_beats.size() > 0) begin
                nxt = pending_beats.pop_front();
                s_valid  <= 1'b1;
                s_cmd    <= nxt.cmd;
                s_old_a  <= nxt.old_a;
                s_old_b  <= nxt.old_b;
                s_new_a  <= nxt.new_a;
                s_new_b  <= nxt.new_b;
                send_gap <= $urandom_range(0, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // predictor hook and result monitor
    always @(posedge aclk) begin
        credit_t got, exp_c;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                beat_t b;
                b.cmd = cmd_t'(s_cmd);
                b.old_a = s_old_a; b.old_b = s_old_b;
                b.new_a = s_new_a; b.new_b = s_new_b;
                expected_credits.push_back(predict_credit(b));
            end
            if (m_valid && m_ready) begin
                results_seen++;
                got.credit = m_credit; got.credit_raw = m_credit_raw;
                got.count = m_window_count; got.full = m_window_full;
                if (expected_credits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat");
                end else begin
                    exp_c = expected_credits.pop_front();
                    if (got != exp_c) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp credit %h raw %h cnt %0d full %0b,",
                                      " got %h %h %0d %0b"},
                                exp_c.credit, exp_c.credit_raw, exp_c.count, exp_c.full,
                                got.credit, got.credit_raw, got.count, got.full);
                    end
                end
            end
            if (m_valid && m_ready) begin
                m_ready  <= 1'b0;
                recv_gap <= $urandom_range(0, 5);
            end else if (recv_gap > 0) begin
                m_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW_SIZE: win_size = val[6:0];
            REG_CREDIT_TYPE: ctype = val[1:0];
            REG_NORMALIZE:   norm_en = val[0];
            REG_DELTA:       delta_en = val[0];
            REG_MAX_REWARD:  max_rew = val[30:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_beats.size() > 0 || s_valid || expected_credits.size() > 0)
            @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_fit();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65536 * 8);
            3: return -$urandom_range(0, 65536 * 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t rand_beat();
        beat_t b;
        int p;
        p = $urandom_range(0, 99);
        b.cmd = p < 40 ? CMD_ADD : p < 68 ? CMD_MUT : p < 96 ? CMD_CROSS : CMD_CLEAR;
        b.old_a = rand_fit(); b.old_b = rand_fit();
        b.new_a = rand_fit(); b.new_b = rand_fit();
        return b;
    endfunction

    function automatic beat_t mk(cmd_t c, logic [31:0] oa, logic [31:0] ob,
                                 logic [31:0] na, logic [31:0] nb);
        beat_t b;
        b.cmd = c; b.old_a = oa; b.old_b = ob; b.new_a = na; b.new_b = nb;
        return b;
    endfunction

    initial begin
        int unsigned wsz [6] = '{1, 64, 0, 127, 3, 17};
        ring = '{default: 0};
        newest = 0; held = 0; wsum = 0; best = 0;
        win_size = 64; ctype = 0; norm_en = 0; delta_en = 0; max_rew = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, overflow, eviction of best
        write_reg(REG_WINDOW_SIZE, 3);
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'h7fffffff, 0));
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'h80000000, 0));
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'h00010000, 0));
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'h00020000, 0));
        pending_beats.push_back(mk(CMD_MUT, 32'h80000000, 0, 32'h7fffffff, 0));
        pending_beats.push_back(mk(CMD_MUT, 32'h7fffffff, 0, 32'h80000000, 0));
        pending_beats.push_back(mk(CMD_CROSS, 5, 9, 3, 12));
        pending_beats.push_back(mk(CMD_CLEAR, 32'hffffffff, 32'hffffffff,
                                   32'hffffffff, 32'hffffffff));
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'hffff0000, 0));
        wait_idle();
        write_reg(REG_DELTA, 1);
        write_reg(REG_CREDIT_TYPE, CT_AVERAGE);
        write_reg(REG_NORMALIZE, 1);
        write_reg(REG_MAX_REWARD, 32'h00008000);
        pending_beats.push_back(mk(CMD_MUT, 32'h80000000, 0, 32'h7fffffff, 0));
        pending_beats.push_back(mk(CMD_MUT, 32'h7fffffff, 0, 32'h80000000, 0));
        pending_beats.push_back(mk(CMD_CROSS, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 0));
        pending_beats.push_back(mk(CMD_CLEAR, 0, 0, 0, 0));
        wait_idle();
        // window of one entry, so the second add evicts the first
        write_reg(REG_WINDOW_SIZE, 1);
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'h00030000, 0));
        pending_beats.push_back(mk(CMD_ADD, 0, 0, 32'h00010000, 0));
        wait_idle();

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_WINDOW_SIZE, wsz[ph % 6]);
            write_reg(REG_CREDIT_TYPE, ph % 4);
            write_reg(REG_NORMALIZE, $urandom_range(0, 1));
            write_reg(REG_DELTA, $urandom_range(0, 1));
            case (ph % 4)
                0: write_reg(REG_MAX_REWARD, 0);
                1: write_reg(REG_MAX_REWARD, 32'h7fffffff);
                2: write_reg(REG_MAX_REWARD, 1);
                default: write_reg(REG_MAX_REWARD, $urandom);
            endcase
            for (int i = 0; i < 65; i++) pending_beats.push_back(rand_beat());
            wait_idle();
        end

        $display("covered %0d result beats over 12 random register settings", results_seen);
        if (mismatches == 0 && expected_credits.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[files.f]
rtl/swct_pkg.sv
rtl/swct_divider.sv
rtl/sliding_window_credit_tracker_core.sv
rtl/swct_checker.sv
tb/tb_sliding_window_credit_tracker_core.sv
